### src/calendar_clock_with_weekday_defines.svh
// assertion macros for the calendar clock block
`ifndef CALENDAR_CLOCK_WITH_WEEKDAY_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_WEEKDAY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CCW_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// next-cycle implication, checked outside reset
`define CCW_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

### src/ccw_pkg.sv
// types, constants and table functions of the calendar clock
`default_nettype none

package ccw_pkg;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } ccw_cmd_e;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [3:0] MONTH_MIN = 4'd1;
  localparam logic [4:0] DAY_MIN   = 5'd1;
  localparam logic [2:0] WDAY_MON  = 3'd1;
  localparam logic [2:0] WDAY_SAT  = 3'd6;
  localparam logic [2:0] WDAY_SUN  = 3'd7;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } ccw_time_t;

  typedef struct packed {
    ccw_cmd_e   command;
    logic [6:0] set_year;
    logic [3:0] set_month;
    logic [4:0] set_day;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic [5:0] set_second;
  } ccw_item_t;

  localparam ccw_time_t TIME_RESET = '{
    year: 7'd0, month: MONTH_MIN, day: DAY_MIN, hour: 5'd0,
    minute: 6'd0, second: 6'd0, weekday: WDAY_SAT
  };

  function automatic logic [4:0] days_in_month(logic [3:0] month, logic [6:0] year);
    logic [4:0] len;
    case (month)
      MONTH_FEB:                        len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:          len = 5'd30;
      default:                          len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_key(logic [3:0] month);
    logic [2:0] key;
    case (month)
      4'd1:    key = 3'd6;
      4'd2:    key = 3'd2;
      4'd3:    key = 3'd2;
      4'd4:    key = 3'd5;
      4'd5:    key = 3'd0;
      4'd6:    key = 3'd3;
      4'd7:    key = 3'd5;
      4'd8:    key = 3'd1;
      4'd9:    key = 3'd4;
      4'd10:   key = 3'd6;
      4'd11:   key = 3'd2;
      4'd12:   key = 3'd4;
      default: key = 3'd0;
    endcase
    return key;
  endfunction

  // table formula, mod 7 by folding octal digits since 8 is 1 mod 7
  function automatic logic [2:0] weekday_of(logic [6:0] y, logic [3:0] m, logic [4:0] d);
    logic       leap_early;
    logic [7:0] sum;
    logic [4:0] fold1;
    logic [3:0] fold2;
    logic [2:0] wday;
    leap_early = (m < MONTH_MAR) && (y[1:0] == 2'd0);
    sum = 8'(y) + 8'(y[6:2]) + 8'(month_key(m)) + 8'(d) + 8'd7 - 8'(leap_early);
    fold1 = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[7:6]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    if (fold2 == 4'd0 || fold2 == 4'd7) begin
      wday = WDAY_SUN;
    end else if (fold2 > 4'd7) begin
      wday = 3'(fold2 - 4'd7);
    end else begin
      wday = fold2[2:0];
    end
    return wday;
  endfunction

endpackage

`default_nettype wire

### src/ccw_intf.sv
// valid/ready channel interfaces for command items and time results
`default_nettype none

interface ccw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [6:0] set_year;
  logic [3:0] set_month;
  logic [4:0] set_day;
  logic [4:0] set_hour;
  logic [5:0] set_minute;
  logic [5:0] set_second;

  modport source (
    output valid, command, set_year, set_month, set_day, set_hour, set_minute,
           set_second,
    input  ready
  );
  modport sink (
    input  valid, command, set_year, set_month, set_day, set_hour, set_minute,
           set_second,
    output ready
  );
endinterface

interface ccw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] year_out;
  logic [3:0] month_out;
  logic [4:0] day_out;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic [2:0] weekday_out;

  modport source (
    output valid, year_out, month_out, day_out, hour_out, minute_out, second_out,
           weekday_out,
    input  ready
  );
  modport sink (
    input  valid, year_out, month_out, day_out, hour_out, minute_out, second_out,
           weekday_out,
    output ready
  );
endinterface

`default_nettype wire

### src/calendar_clock_with_weekday.sv
// calendar clock top level: input register, update logic, time register
`default_nettype none

`include "calendar_clock_with_weekday_defines.svh"

// Calendar clock, years 2000 to 2099, weekday 1 Monday to 7 Sunday, reset to
// Saturday 1 January 2000 00:00:00. Each command transfer either advances one
// second or loads date and time (fields saturate into range, the day only at
// its minimum; weekday computed), and gives one result transfer with the time
// after the command. One command is taken every cycle while the result is not
// stalled, since the update is a single pass of logic between the input register
// and the time register, which doubles as the result register. A stalled result
// holds the pipe, with at most one command waiting in the input register.
module calendar_clock_with_weekday
  import ccw_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  ccw_in_if.sink       in_i,
  ccw_out_if.source    out_o
);

  logic      in_vld_q;
  ccw_item_t in_q;
  logic      out_vld_q;
  ccw_time_t time_q;
  ccw_time_t time_d;
  ccw_time_t tick_nxt;
  ccw_time_t load_nxt;
  logic      adv;
  logic      in_rdy;

  assign adv    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_rdy = !in_vld_q || adv;

  ccw_tick u_tick (
    .cur_i (time_q),
    .nxt_o (tick_nxt)
  );

  ccw_load u_load (
    .item_i (in_q),
    .nxt_o  (load_nxt)
  );

  assign time_d = (in_q.command == CMD_LOAD) ? load_nxt : tick_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      time_q    <= TIME_RESET;
    end else begin
      if (in_rdy) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        time_q    <= time_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_rdy) begin
      in_q.command    <= ccw_cmd_e'(in_i.command);
      in_q.set_year   <= in_i.set_year;
      in_q.set_month  <= in_i.set_month;
      in_q.set_day    <= in_i.set_day;
      in_q.set_hour   <= in_i.set_hour;
      in_q.set_minute <= in_i.set_minute;
      in_q.set_second <= in_i.set_second;
    end
  end

  assign in_i.ready        = in_rdy;
  assign out_o.valid       = out_vld_q;
  assign out_o.year_out    = time_q.year;
  assign out_o.month_out   = time_q.month;
  assign out_o.day_out     = time_q.day;
  assign out_o.hour_out    = time_q.hour;
  assign out_o.minute_out  = time_q.minute;
  assign out_o.second_out  = time_q.second;
  assign out_o.weekday_out = time_q.weekday;

  // time must not move while a result waits
  `CCW_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_vld_q && !out_o.ready, $stable(time_q))
  // full input stage behind a stalled result blocks new commands
  `CCW_ASSERT_NOW(a_ready_blocked, clk_i, rst_ni, in_vld_q && out_vld_q && !out_o.ready, !in_rdy)
  // weekday never shows the formula's zero
  `CCW_ASSERT_NOW(a_weekday_nonzero, clk_i, rst_ni, out_vld_q, time_q.weekday != 3'd0)
  // clock fields stay in range
  `CCW_ASSERT_NOW(a_time_range, clk_i, rst_ni, out_vld_q,
                  time_q.second <= SEC_MAX && time_q.minute <= SEC_MAX && time_q.hour <= HOUR_MAX)

endmodule

`default_nettype wire

### src/ccw_tick.sv
// one-second advance with carry through minute, hour, day, month and year
`default_nettype none

module ccw_tick
  import ccw_pkg::*;
(
  input  ccw_time_t cur_i,
  output ccw_time_t nxt_o
);

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.second >= SEC_MAX) begin
      nxt_o.second = 6'd0;
      if (cur_i.minute >= SEC_MAX) begin
        nxt_o.minute = 6'd0;
        if (cur_i.hour >= HOUR_MAX) begin
          nxt_o.hour    = 5'd0;
          nxt_o.weekday = (cur_i.weekday >= WDAY_SUN) ? WDAY_MON : cur_i.weekday + 3'd1;
          // a loaded day past the month length also wraps here
          if (cur_i.day >= days_in_month(cur_i.month, cur_i.year)) begin
            nxt_o.day = DAY_MIN;
            if (cur_i.month >= MONTH_MAX) begin
              nxt_o.month = MONTH_MIN;
              nxt_o.year  = (cur_i.year >= YEAR_MAX) ? 7'd0 : cur_i.year + 7'd1;
            end else begin
              nxt_o.month = cur_i.month + 4'd1;
            end
          end else begin
            nxt_o.day = cur_i.day + 5'd1;
          end
        end else begin
          nxt_o.hour = cur_i.hour + 5'd1;
        end
      end else begin
        nxt_o.minute = cur_i.minute + 6'd1;
      end
    end else begin
      nxt_o.second = cur_i.second + 6'd1;
    end
  end

endmodule

`default_nettype wire

### src/ccw_load.sv
// load path: saturate the set fields and derive the weekday
`default_nettype none

module ccw_load
  import ccw_pkg::*;
(
  input  ccw_item_t item_i,
  output ccw_time_t nxt_o
);

  ccw_time_t sat;

  always_comb begin
    sat.year   = (item_i.set_year > YEAR_MAX) ? YEAR_MAX : item_i.set_year;
    if (item_i.set_month < MONTH_MIN) begin
      sat.month = MONTH_MIN;
    end else if (item_i.set_month > MONTH_MAX) begin
      sat.month = MONTH_MAX;
    end else begin
      sat.month = item_i.set_month;
    end
    sat.day     = (item_i.set_day < DAY_MIN) ? DAY_MIN : item_i.set_day;
    sat.hour    = (item_i.set_hour > HOUR_MAX) ? HOUR_MAX : item_i.set_hour;
    sat.minute  = (item_i.set_minute > SEC_MAX) ? SEC_MAX : item_i.set_minute;
    sat.second  = (item_i.set_second > SEC_MAX) ? SEC_MAX : item_i.set_second;
    sat.weekday = WDAY_SUN;
  end

  always_comb begin
    nxt_o         = sat;
    nxt_o.weekday = weekday_of(sat.year, sat.month, sat.day);
  end

endmodule

`default_nettype wire
